FILE: hw/rtl/ism_pkg.sv
// Shared constants and command codes for the interval set manager.
`default_nettype none
package ism_pkg;
  localparam int DEF_MAX_INTERVALS = 64;
  localparam int DEF_COORD_BITS    = 31;
  localparam int CMD_BITS          = 2;
  localparam int COUNT_OUT_BITS    = 7;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2
  } ism_cmd_t;
endpackage
`default_nettype wire

FILE: hw/rtl/ism_mem.sv
// Interval table storage: one write port, one registered read port.
`default_nettype none
module ism_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 62
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/interval_set_manager_core.sv
// Interval set manager: sorted table of disjoint intervals with add/remove/query.
//
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+---------------------------
//  request  | in_command, in_range_start, in_range_end      | taken when start && !busy
//  result   | out_covered, out_table_full, out_interval_count | out_valid, one cycle
//
// Operation: a request walks the table through the single read port of the
// table memory, entry by entry, then shifts the tail one entry at a time
// and writes up to two new entries. Empty ranges and unknown commands go
// straight to the done state. The result shows up in the same cycle that
// busy drops.
// Reset: rst_n (synchronous, active low) empties the table; entry contents
// are not cleared, entries beyond the count are never used.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module interval_set_manager_core #(
  parameter int MAX_INTERVALS = ism_pkg::DEF_MAX_INTERVALS,
  parameter int COORD_BITS    = ism_pkg::DEF_COORD_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [ism_pkg::CMD_BITS-1:0]       in_command,
  input  wire logic [COORD_BITS-1:0]              in_range_start,
  input  wire logic [COORD_BITS-1:0]              in_range_end,
  output logic                                    out_valid,
  output logic                                    out_covered,
  output logic                                    out_table_full,
  output logic [ism_pkg::COUNT_OUT_BITS-1:0]      out_interval_count
);
  import ism_pkg::*;

  localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int EW = 2 * COORD_BITS;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_INTERVALS);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CK, S_PLAN, S_UP_RD, S_UP_WR,
    S_DN_RD, S_DN_WR, S_PC0, S_PC1, S_DONE
  } state_t;

  state_t                state_r;
  logic [CMD_BITS-1:0]   cmd_r;
  logic [COORD_BITS-1:0] s_r, e_r, first_r, last_r;
  logic [CW-1:0]         cnt_r, idx_r, i_r, j_r, src_r, dst_r, base_r, newcnt_r;
  logic                  ph_r, cov_r, full_r;
  logic [1:0]            np_r;
  logic [EW-1:0]         p0_r, p1_r;

  // memory port
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_rdata;
  logic [COORD_BITS-1:0] rd_s, rd_e;

  assign rd_s = mem_rdata[EW-1:COORD_BITS];
  assign rd_e = mem_rdata[COORD_BITS-1:0];

  ism_mem #(.DEPTH(MAX_INTERVALS), .WIDTH(EW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  // scan predicates: add skips entries ending before start and absorbs touching ones
  logic is_add, skip_ent, take_ent;
  assign is_add   = (cmd_r == CMD_ADD);
  assign skip_ent = is_add ? (rd_e < s_r) : (rd_e <= s_r);
  assign take_ent = is_add ? (rd_s <= e_r) : (rd_s < e_r);

  // remove plan
  logic keep_l, keep_r, split;
  assign keep_l = first_r < s_r;
  assign keep_r = last_r > e_r;
  assign split  = (j_r == i_r + CW'(1)) && keep_l && keep_r;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r[AW-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = idx_r[AW-1:0];
    unique case (state_r)
      S_UP_RD: mem_raddr = AW'(idx_r - CW'(1));
      S_UP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
      end
      S_DN_WR: begin
        mem_we    = 1'b1;
        mem_waddr = dst_r[AW-1:0];
      end
      S_PC0: begin
        mem_we    = (np_r != 2'd0);
        mem_waddr = base_r[AW-1:0];
        mem_wdata = p0_r;
      end
      S_PC1: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(base_r + CW'(1));
        mem_wdata = p1_r;
      end
      default: ;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r    <= in_command;
            s_r      <= in_range_start;
            e_r      <= in_range_end;
            idx_r    <= '0;
            ph_r     <= 1'b0;
            cov_r    <= 1'b0;
            full_r   <= 1'b0;
            newcnt_r <= cnt_r;
            if (in_range_start < in_range_end &&
                (in_command == CMD_ADD || in_command == CMD_REMOVE ||
                 in_command == CMD_QUERY)) begin
              state_r <= S_SCAN_RD;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_SCAN_RD: begin
          if (idx_r == cnt_r) begin
            if (!ph_r) begin
              i_r <= cnt_r;
              j_r <= cnt_r;
            end
            state_r <= S_PLAN;
          end else begin
            state_r <= S_SCAN_CK;
          end
        end
        S_SCAN_CK: begin
          if (cmd_r == CMD_QUERY) begin
            if (rd_s <= s_r && rd_e >= e_r) cov_r <= 1'b1;
            idx_r   <= idx_r + CW'(1);
            state_r <= S_SCAN_RD;
          end else if (!ph_r && skip_ent) begin
            idx_r   <= idx_r + CW'(1);
            state_r <= S_SCAN_RD;
          end else if (take_ent) begin
            if (!ph_r) begin
              i_r     <= idx_r;
              first_r <= rd_s;
              ph_r    <= 1'b1;
            end
            last_r  <= rd_e;
            j_r     <= idx_r + CW'(1);
            idx_r   <= idx_r + CW'(1);
            state_r <= S_SCAN_RD;
          end else begin
            if (!ph_r) begin
              i_r <= idx_r;
              j_r <= idx_r;
            end
            state_r <= S_PLAN;
          end
        end
        S_PLAN: begin
          base_r  <= i_r;
          state_r <= S_DONE;
          if (cmd_r == CMD_ADD) begin
            if (i_r == j_r) begin
              if (cnt_r >= MAX_CNT) begin
                full_r <= 1'b1;
              end else begin
                p0_r     <= {s_r, e_r};
                np_r     <= 2'd1;
                src_r    <= i_r;
                idx_r    <= cnt_r;
                newcnt_r <= cnt_r + CW'(1);
                state_r  <= S_UP_RD;
              end
            end else begin
              p0_r    <= {(first_r < s_r) ? first_r : s_r, (last_r > e_r) ? last_r : e_r};
              np_r    <= 2'd1;
              src_r   <= j_r;
              dst_r   <= i_r + CW'(1);
              idx_r   <= j_r;
              state_r <= S_DN_RD;
            end
          end else if (cmd_r == CMD_REMOVE && i_r != j_r) begin
            if (split) begin
              if (cnt_r >= MAX_CNT) begin
                full_r <= 1'b1;
              end else begin
                p0_r     <= {first_r, s_r};
                p1_r     <= {e_r, last_r};
                np_r     <= 2'd2;
                src_r    <= i_r + CW'(1);
                idx_r    <= cnt_r;
                newcnt_r <= cnt_r + CW'(1);
                state_r  <= S_UP_RD;
              end
            end else begin
              p0_r    <= keep_l ? {first_r, s_r} : {e_r, last_r};
              p1_r    <= {e_r, last_r};
              np_r    <= 2'({1'b0, keep_l} + {1'b0, keep_r});
              src_r   <= j_r;
              dst_r   <= i_r + CW'({1'b0, keep_l} + {1'b0, keep_r});
              idx_r   <= j_r;
              state_r <= S_DN_RD;
            end
          end
        end
        S_UP_RD: begin
          if (idx_r == src_r) state_r <= S_PC0;
          else state_r <= S_UP_WR;
        end
        S_UP_WR: begin
          idx_r   <= idx_r - CW'(1);
          state_r <= S_UP_RD;
        end
        S_DN_RD: begin
          if (idx_r == cnt_r) begin
            // destination pointer has passed the whole tail: it is the new count
            newcnt_r <= dst_r;
            state_r  <= S_PC0;
          end else begin
            state_r <= S_DN_WR;
          end
        end
        S_DN_WR: begin
          idx_r   <= idx_r + CW'(1);
          dst_r   <= dst_r + CW'(1);
          state_r <= S_DN_RD;
        end
        S_PC0: begin
          if (np_r == 2'd2) state_r <= S_PC1;
          else state_r <= S_DONE;
        end
        S_PC1: state_r <= S_DONE;
        S_DONE: begin
          cnt_r              <= newcnt_r;
          out_valid          <= 1'b1;
          out_covered        <= cov_r;
          out_table_full     <= full_r;
          out_interval_count <= COUNT_OUT_BITS'(newcnt_r);
          state_r            <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
